[rtl/core/pfa_pkg.sv]
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants of the partition fit allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

	// fixed field widths of the request and response channels
	localparam int CMD_W   = 1;
	localparam int SEL_W   = 4;
	localparam int AMT_W   = 16;
	localparam int REM_W   = 16;
	localparam int TOTAL_W = 20;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int PARTS_W = 5;

	localparam logic [PARTS_W-1:0] PARTS_RESET = 5'd16;

	// register indexes (one 32-bit word each)
	localparam logic REG_FIT_POLICY   = 1'b0;
	localparam logic REG_PARTS_IN_USE = 1'b1;

	// request commands
	localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
	localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

	typedef enum logic [1:0] {
		POL_FIRST = 2'd0,
		POL_BEST  = 2'd1,
		POL_WORST = 2'd2
	} fit_policy_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

	// configuration register contents
	typedef struct packed {
		fit_policy_t              policy;
		logic [PARTS_W-1:0]       parts_in_use;
	} cfg_t;

	// broadcast to every cell during a scan
	typedef struct packed {
		fit_policy_t              policy;
		logic [PARTS_W-1:0]       parts_in_use;
		logic [AMT_W-1:0]         req;
	} scan_ctrl_t;

endpackage

[rtl/core/pfa_stream_if.sv]
// ----------------------------------------------------------------------------
// pfa_req_if / pfa_rsp_if
// Valid/ready channels carrying allocator requests and responses.
// ----------------------------------------------------------------------------
interface pfa_req_if;
	logic        valid;
	logic        ready;
	logic [0:0]  command;
	logic [3:0]  part_select;
	logic [15:0] amount;

	modport source (output valid, command, part_select, amount, input ready);
	modport sink (input valid, command, part_select, amount, output ready);
endinterface

interface pfa_rsp_if;
	logic        valid;
	logic        ready;
	logic        granted;
	logic [3:0]  part_index;
	logic [15:0] part_remaining;
	logic [19:0] total_free;

	modport source (output valid, granted, part_index, part_remaining, total_free,
		input ready);
	modport sink (input valid, granted, part_index, part_remaining, total_free,
		output ready);
endinterface

[rtl/core/pfa_cfg.sv]
// ----------------------------------------------------------------------------
// pfa_cfg
// APB register file holding the fit policy and the scanned partition count.
// ----------------------------------------------------------------------------
module pfa_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pfa_pkg::PADDR_W-1:0] paddr,
	input  logic [pfa_pkg::PDATA_W-1:0] pwdata,
	output logic [pfa_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output pfa_pkg::cfg_t               cfg
);
	import pfa_pkg::*;

	cfg_t cfg_q;
	logic wr_stb;
	logic reg_sel;

	assign pready  = 1'b1;
	assign wr_stb  = psel && penable && pwrite;
	// one word per register, byte lanes ignored
	assign reg_sel = paddr[2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.policy       <= POL_FIRST;
			cfg_q.parts_in_use <= PARTS_RESET;
		end else if (wr_stb) begin
			unique case (reg_sel)
				REG_FIT_POLICY:   cfg_q.policy <= fit_policy_t'(pwdata[1:0]);
				REG_PARTS_IN_USE: cfg_q.parts_in_use <= pwdata[PARTS_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_sel)
			REG_FIT_POLICY:   prdata = PDATA_W'(cfg_q.policy);
			REG_PARTS_IN_USE: prdata = PDATA_W'(cfg_q.parts_in_use);
			default:          prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/pfa_cell.sv]
// ----------------------------------------------------------------------------
// pfa_cell
// One partition: holds its free size and folds itself into the candidate
// handed down the chain from the previous cell.
// ----------------------------------------------------------------------------
module pfa_cell #(
	parameter int IDX_W     = 4,
	parameter int SIZE_BITS = 16,
	parameter int CELL_IDX  = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pfa_pkg::scan_ctrl_t    ctrl,
	input  logic                   found_in,
	input  logic [IDX_W-1:0]       idx_in,
	input  logic [SIZE_BITS-1:0]   size_in,
	output logic                   found_out,
	output logic [IDX_W-1:0]       idx_out,
	output logic [SIZE_BITS-1:0]   size_out,
	input  logic                   wr_en,
	input  logic [SIZE_BITS-1:0]   wr_data,
	output logic [SIZE_BITS-1:0]   entry
);
	import pfa_pkg::*;

	localparam int CMP_W = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

	logic [SIZE_BITS-1:0] entry_q;
	logic                 found_q;
	logic [IDX_W-1:0]     idx_q;
	logic [SIZE_BITS-1:0] size_q;
	logic                 in_scan;
	logic                 fits;
	logic                 take;

	assign in_scan = 32'(ctrl.parts_in_use) > CELL_IDX;
	assign fits    = CMP_W'(ctrl.req) <= CMP_W'(entry_q);

	// does this partition replace the incoming candidate
	always_comb begin
		case (ctrl.policy)
			POL_FIRST: take = !found_in && fits;
			POL_BEST:  take = fits && (!found_in || entry_q < size_in);
			POL_WORST: take = !found_in || entry_q > size_in;
			default:   take = 1'b0;
		endcase
		take = take && in_scan;
	end

	// candidate stage toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else begin
			found_q <= found_in || take;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= take ? IDX_W'(CELL_IDX) : idx_in;
		size_q <= take ? entry_q : size_in;
	end

	// free size of this partition
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (wr_en) begin
			entry_q <= wr_data;
		end
	end

	assign found_out = found_q;
	assign idx_out   = idx_q;
	assign size_out  = size_q;
	assign entry     = entry_q;

endmodule

[rtl/core/partition_fit_allocator_top.sv]
// ----------------------------------------------------------------------------
// partition_fit_allocator_top
// Fixed-partition allocator with first, best and worst fit over a cell chain.
// ----------------------------------------------------------------------------
// One item is handled at a time. A load request goes from idle straight to the
// write-back state (write-back only); an allocate request first passes the
// scan state, in which the candidate walks the chain of NUM_PARTS partition
// cells one cell per clock, and then the write-back state, where the response
// register is loaded. The write-back cycle repeats for as long as the previous
// response is still held. A new request is accepted on the cycle after the
// response register is loaded, even if that response has not yet been taken.
// Configuration writes must be done while no request is in flight. The
// partition table and the running free total clear at reset; there is no
// clearing pass.
module partition_fit_allocator_top #(
	parameter int NUM_PARTS = 16,
	parameter int SIZE_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	pfa_req_if.sink                     req,
	pfa_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pfa_pkg::PADDR_W-1:0] paddr,
	input  logic [pfa_pkg::PDATA_W-1:0] pwdata,
	output logic [pfa_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import pfa_pkg::*;

	localparam int IDX_W = $clog2(NUM_PARTS);
	localparam int CNT_W = $clog2(NUM_PARTS);
	localparam int CMP_W = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

	cfg_t       cfg;
	scan_ctrl_t ctrl;
	state_t     state_q;
	state_t     state_nxt;

	logic [CNT_W-1:0]   cnt_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [SEL_W-1:0]   sel_q;
	logic [AMT_W-1:0]   amt_q;
	logic [TOTAL_W-1:0] total_q;

	logic               rsp_valid_q;
	logic               rsp_granted_q;
	logic [SEL_W-1:0]   rsp_index_q;
	logic [REM_W-1:0]   rsp_rem_q;
	logic [TOTAL_W-1:0] rsp_total_q;

	logic                 found_c [NUM_PARTS+1];
	logic [IDX_W-1:0]     idx_c   [NUM_PARTS+1];
	logic [SIZE_BITS-1:0] size_c  [NUM_PARTS+1];
	logic [SIZE_BITS-1:0] entries [NUM_PARTS];
	logic [NUM_PARTS-1:0] cell_wr;

	logic                 req_fire;
	logic                 out_free;
	logic                 fire;
	logic                 is_load;
	logic                 load_ok;
	logic                 granted;
	logic                 wr_any;
	logic [IDX_W-1:0]     sel_idx;
	logic [IDX_W-1:0]     wr_idx;
	logic [SIZE_BITS-1:0] new_size;
	logic [SIZE_BITS-1:0] wr_data;
	logic [SIZE_BITS-1:0] old_size;
	logic [SIZE_BITS-1:0] best_size;
	logic [TOTAL_W-1:0]   total_nxt;

	// configuration registers
	pfa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign ctrl.policy       = cfg.policy;
	assign ctrl.parts_in_use = cfg.parts_in_use;
	assign ctrl.req          = amt_q;

	// empty candidate enters the head of the chain
	assign found_c[0] = 1'b0;
	assign idx_c[0]   = '0;
	assign size_c[0]  = '0;

	// chain of partition cells
	for (genvar i = 0; i < NUM_PARTS; i++) begin : g_cell
		assign cell_wr[i] = wr_any && (wr_idx == IDX_W'(i));

		pfa_cell #(
			.IDX_W     (IDX_W),
			.SIZE_BITS (SIZE_BITS),
			.CELL_IDX  (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.found_in  (found_c[i]),
			.idx_in    (idx_c[i]),
			.size_in   (size_c[i]),
			.found_out (found_c[i+1]),
			.idx_out   (idx_c[i+1]),
			.size_out  (size_c[i+1]),
			.wr_en     (cell_wr[i]),
			.wr_data   (wr_data),
			.entry     (entries[i])
		);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_nxt = (req.command == CMD_LOAD) ? ST_WRITE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == CNT_W'(NUM_PARTS - 1)) begin
					state_nxt = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		req.ready = 1'b0;
		fire      = 1'b0;
		unique case (state_q)
			ST_IDLE:  req.ready = 1'b1;
			ST_SCAN:  ;
			ST_WRITE: fire = out_free;
			default:  ;
		endcase
	end

	assign req_fire = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;

	// state, scan counter and captured request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= (state_q == ST_SCAN) ? cnt_q + CNT_W'(1) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q <= req.command;
			sel_q <= req.part_select;
			amt_q <= req.amount;
		end
	end

	// decision at the tail of the chain
	assign is_load   = (cmd_q == CMD_LOAD);
	assign load_ok   = 32'(sel_q) < NUM_PARTS;
	assign sel_idx   = IDX_W'(sel_q);
	assign old_size  = entries[sel_idx];
	assign new_size  = SIZE_BITS'(amt_q);
	assign best_size = size_c[NUM_PARTS];
	assign granted   = !is_load && found_c[NUM_PARTS] &&
		((cfg.policy != POL_WORST) || (CMP_W'(amt_q) <= CMP_W'(best_size)));

	assign wr_idx  = is_load ? sel_idx : idx_c[NUM_PARTS];
	assign wr_data = is_load ? new_size
		: SIZE_BITS'(CMP_W'(best_size) - CMP_W'(amt_q));
	assign wr_any  = fire && ((is_load && load_ok) || granted);

	// running free total
	always_comb begin
		total_nxt = total_q;
		if (is_load && load_ok) begin
			total_nxt = total_q - TOTAL_W'(old_size) + TOTAL_W'(new_size);
		end else if (granted) begin
			total_nxt = total_q - TOTAL_W'(amt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (fire) begin
			total_q <= total_nxt;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_granted_q <= granted;
			rsp_total_q   <= total_nxt;
			if (is_load) begin
				rsp_index_q <= sel_q;
				rsp_rem_q   <= load_ok ? REM_W'(new_size) : '0;
			end else begin
				rsp_index_q <= granted ? SEL_W'(idx_c[NUM_PARTS]) : '0;
				rsp_rem_q   <= granted ? REM_W'(wr_data) : '0;
			end
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.granted        = rsp_granted_q;
	assign rsp.part_index     = rsp_index_q;
	assign rsp.part_remaining = rsp_rem_q;
	assign rsp.total_free     = rsp_total_q;

	// at most one partition is written per request
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_wr))
		else $error("more than one partition written");

	// an accepted request leaves idle until its response is loaded
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> state_q != ST_IDLE)
		else $error("request accepted without leaving idle");

	// a new response appears only out of the write-back cycle
	a_rsp_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_WRITE)
		else $error("response raised outside write-back");

	// a stalled write-back keeps the captured request intact
	a_write_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && !out_free) |=>
			(state_q == ST_WRITE && $stable(amt_q) && $stable(cmd_q)))
		else $error("write-back lost while response stalled");

endmodule
